/* rtl/itoa_pkg.sv */
// Package for the signed integer to decimal text unit.
// Holds shared constants, character codes and the converter state type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package itoa_pkg;

	// default width of the input integer
	localparam int VALUE_BITS_DEF = 32;

	// ASCII output character width and codes
	localparam int          CHAR_W     = 6;
	localparam logic [5:0]  CHAR_ZERO  = 6'd48;
	localparam logic [5:0]  CHAR_MINUS = 6'd45;

	// magnitude bits folded into the BCD register per converter cycle
	localparam int DABBLE_BITS = 4;

	// depth of the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		CONV_IDLE,
		CONV_RUN,
		CONV_DONE
	} conv_state_t;

endpackage

`default_nettype wire

/* rtl/itoa_front.sv */
// Front part: accepts one integer per request and splits it into sign and magnitude.
// Depends on itoa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module itoa_front import itoa_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [VALUE_BITS-1:0] value,
	input  wire logic                  value_valid,
	output logic                       value_ready,
	output logic                       cls_valid,
	input  wire logic                  cls_ready,
	output logic                       cls_neg,
	output logic [VALUE_BITS-1:0]      cls_mag
);

	logic                  valid_q;
	logic                  neg_q;
	logic [VALUE_BITS-1:0] mag_q;
	logic                  take;
	logic                  neg_d;

	// accept when the holding register is empty or drains this cycle
	assign value_ready = !valid_q || cls_ready;
	assign take        = value_valid && value_ready;
	assign neg_d       = value[VALUE_BITS-1];

	// hold the valid flag of the classified request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= 1'b1;
		end else if (cls_ready) begin
			valid_q <= 1'b0;
		end
	end

	// form the unsigned magnitude; the most negative value negates to itself
	always_ff @(posedge clk) begin
		if (take) begin
			neg_q <= neg_d;
			mag_q <= neg_d ? (~value + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : value;
		end
	end

	assign cls_valid = valid_q;
	assign cls_neg   = neg_q;
	assign cls_mag   = mag_q;

endmodule

`default_nettype wire

/* rtl/itoa_queue.sv */
// Short queue of classified requests between the front and the converter.
// Depends on itoa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module itoa_queue import itoa_pkg::*; #(
	parameter int WIDTH = VALUE_BITS_DEF + 1,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [WIDTH-1:0] push_data,
	input  wire logic             push_valid,
	output logic                  push_ready,
	output logic [WIDTH-1:0]      pop_data,
	output logic                  pop_valid,
	input  wire logic             pop_ready
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rptr_q];

	// store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_data;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/itoa_conv.sv */
// Back part, first half: shift-and-add-3 conversion of the magnitude to BCD digits.
// Folds DABBLE_BITS magnitude bits per cycle and finds the leading digit. Depends on itoa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module itoa_conv import itoa_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  req_valid,
	output logic                       req_ready,
	input  wire logic                  req_neg,
	input  wire logic [VALUE_BITS-1:0] req_mag,
	output logic                       res_valid,
	input  wire logic                  res_ready,
	output logic                       res_neg,
	output logic [$clog2(VALUE_BITS * 30103 / 100000 + 1)-1:0] res_top,
	output logic [(VALUE_BITS * 30103 / 100000 + 1)*4-1:0]     res_bcd
);

	localparam int DIGITS = VALUE_BITS * 30103 / 100000 + 1;
	localparam int IDX_W  = $clog2(DIGITS);
	localparam int STEPS  = (VALUE_BITS + DABBLE_BITS - 1) / DABBLE_BITS;
	localparam int MAG_W  = STEPS * DABBLE_BITS;
	localparam int BCD_W  = DIGITS * 4;
	localparam int WORK_W = BCD_W + MAG_W;
	localparam int CNT_W  = (STEPS > 1) ? $clog2(STEPS) : 1;

	conv_state_t      state_q;
	conv_state_t      state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             neg_q;
	logic [MAG_W-1:0] mag_q;
	logic [BCD_W-1:0] bcd_q;
	logic [WORK_W-1:0] work;
	logic [IDX_W-1:0]  top;
	logic              load;
	logic              step;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			CONV_IDLE: if (req_valid) state_d = CONV_RUN;
			CONV_RUN:  if (cnt_q == '0) state_d = CONV_DONE;
			CONV_DONE: if (res_ready) state_d = CONV_IDLE;
			default:   state_d = CONV_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		req_ready = 1'b0;
		res_valid = 1'b0;
		step      = 1'b0;
		case (state_q)
			CONV_IDLE: req_ready = 1'b1;
			CONV_RUN:  step      = 1'b1;
			CONV_DONE: res_valid = 1'b1;
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

	assign load = req_valid && req_ready;

	// one group of add-3-and-shift steps
	always_comb begin
		work = {bcd_q, mag_q};
		for (int s = 0; s < DABBLE_BITS; s++) begin
			for (int d = 0; d < DIGITS; d++) begin
				if (work[MAG_W + 4*d +: 4] >= 4'd5) begin
					work[MAG_W + 4*d +: 4] = work[MAG_W + 4*d +: 4] + 4'd3;
				end
			end
			work = {work[WORK_W-2:0], 1'b0};
		end
	end

	// locate the most significant nonzero digit; zero reports digit 0
	always_comb begin
		top = '0;
		for (int d = 0; d < DIGITS; d++) begin
			if (bcd_q[4*d +: 4] != 4'd0) begin
				top = IDX_W'(d);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CONV_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (load) begin
				cnt_q <= CNT_W'(STEPS - 1);
			end else if (step) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// load and fold the magnitude
	always_ff @(posedge clk) begin
		if (load) begin
			neg_q <= req_neg;
			mag_q <= MAG_W'(req_mag);
			bcd_q <= '0;
		end else if (step) begin
			bcd_q <= work[WORK_W-1 -: BCD_W];
			mag_q <= work[MAG_W-1:0];
		end
	end

	assign res_neg = neg_q;
	assign res_top = top;
	assign res_bcd = bcd_q;

endmodule

`default_nettype wire

/* rtl/itoa_emit.sv */
// Back part, second half: sends sign and digits, one per cycle unless stalled.
// Output register decouples it from the consumer. Depends on itoa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module itoa_emit import itoa_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  res_valid,
	output logic                       res_ready,
	input  wire logic                  res_neg,
	input  wire logic [$clog2(VALUE_BITS * 30103 / 100000 + 1)-1:0] res_top,
	input  wire logic [(VALUE_BITS * 30103 / 100000 + 1)*4-1:0]     res_bcd,
	output logic [CHAR_W-1:0]          character,
	output logic                       last,
	output logic                       char_valid,
	input  wire logic                  char_ready
);

	localparam int DIGITS = VALUE_BITS * 30103 / 100000 + 1;
	localparam int IDX_W  = $clog2(DIGITS);
	localparam int BCD_W  = DIGITS * 4;

	logic              busy_q;
	logic              neg_q;
	logic [IDX_W-1:0]  idx_q;
	logic [BCD_W-1:0]  bcd_q;
	logic              valid_q;
	logic [CHAR_W-1:0] char_q;
	logic              last_q;
	logic              load;
	logic              adv;
	logic [3:0]        digit;

	assign res_ready = !busy_q;
	assign load      = res_valid && res_ready;
	assign adv       = busy_q && (!valid_q || char_ready);
	assign digit     = bcd_q[4*idx_q +: 4];

	// walk the sign then the digits from the leading one down
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			neg_q   <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
				neg_q  <= res_neg;
			end else if (adv) begin
				if (neg_q) begin
					neg_q <= 1'b0;
				end else if (idx_q == '0) begin
					busy_q <= 1'b0;
				end
			end
			if (adv) begin
				valid_q <= 1'b1;
			end else if (char_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// hold digits and the output character
	always_ff @(posedge clk) begin
		if (load) begin
			bcd_q <= res_bcd;
			idx_q <= res_top;
		end else if (adv && !neg_q && idx_q != '0) begin
			idx_q <= idx_q - 1'b1;
		end
		if (adv) begin
			if (neg_q) begin
				char_q <= CHAR_MINUS;
				last_q <= 1'b0;
			end else begin
				char_q <= CHAR_ZERO + {2'b00, digit};
				last_q <= (idx_q == '0);
			end
		end
	end

	assign character  = char_q;
	assign last       = last_q;
	assign char_valid = valid_q;

	// a minus sign never closes a number
	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && character == CHAR_MINUS |-> !last)
		else $error("minus sign flagged as last");

	// characters are the minus sign or a decimal digit
	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid |-> character == CHAR_MINUS ||
			(character >= CHAR_ZERO && character <= CHAR_ZERO + 6'd9))
		else $error("character out of range");

	// a new number is taken only once the previous one's last digit is registered
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> busy_q && $past(!busy_q))
		else $error("number loaded while busy");

endmodule

`default_nettype wire

/* rtl/signed_integer_to_decimal_ascii_unit.sv */
// Top level of the signed integer to decimal text unit.
// Instantiates itoa_front, itoa_queue, itoa_conv and itoa_emit; depends on itoa_pkg.
//
//  Channel   Direction  Handshake                 Payload
//  value     in         value_valid/value_ready   value[VALUE_BITS-1:0], signed
//  char      out        char_valid/char_ready     character[5:0], last
//
// Each number yields its sign (if negative) and digits, one per cycle unless stalled.
// The converter folds 4 magnitude bits per cycle, then hands the digits to the emitter
// once the emitter has moved the last character of the previous number to its output.
// The converter can then work on the next number while the emitter sends characters;
// the emitter's character loop sets the sustained rate for long numbers.
// Reset clears all control state at once. A two-entry queue lets the front keep
// accepting while the back is stalled by the consumer.
`timescale 1ns / 1ps
`default_nettype none

module signed_integer_to_decimal_ascii_unit import itoa_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [VALUE_BITS-1:0] value,
	input  wire logic                  value_valid,
	output logic                       value_ready,
	output logic [CHAR_W-1:0]          character,
	output logic                       last,
	output logic                       char_valid,
	input  wire logic                  char_ready
);

	localparam int DIGITS = VALUE_BITS * 30103 / 100000 + 1;
	localparam int IDX_W  = $clog2(DIGITS);
	localparam int Q_W    = VALUE_BITS + 1;

	logic                  cls_valid;
	logic                  cls_ready;
	logic                  cls_neg;
	logic [VALUE_BITS-1:0] cls_mag;
	logic [Q_W-1:0]        q_data;
	logic                  q_valid;
	logic                  q_ready;
	logic                  res_valid;
	logic                  res_ready;
	logic                  res_neg;
	logic [IDX_W-1:0]      res_top;
	logic [DIGITS*4-1:0]   res_bcd;

	itoa_front #(.VALUE_BITS(VALUE_BITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.value      (value),
		.value_valid(value_valid),
		.value_ready(value_ready),
		.cls_valid  (cls_valid),
		.cls_ready  (cls_ready),
		.cls_neg    (cls_neg),
		.cls_mag    (cls_mag)
	);

	itoa_queue #(.WIDTH(Q_W), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_data ({cls_neg, cls_mag}),
		.push_valid(cls_valid),
		.push_ready(cls_ready),
		.pop_data  (q_data),
		.pop_valid (q_valid),
		.pop_ready (q_ready)
	);

	itoa_conv #(.VALUE_BITS(VALUE_BITS)) u_conv (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(q_valid),
		.req_ready(q_ready),
		.req_neg  (q_data[Q_W-1]),
		.req_mag  (q_data[VALUE_BITS-1:0]),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_neg  (res_neg),
		.res_top  (res_top),
		.res_bcd  (res_bcd)
	);

	itoa_emit #(.VALUE_BITS(VALUE_BITS)) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_neg   (res_neg),
		.res_top   (res_top),
		.res_bcd   (res_bcd),
		.character (character),
		.last      (last),
		.char_valid(char_valid),
		.char_ready(char_ready)
	);

endmodule

`default_nettype wire

/* tb/signed_integer_to_decimal_ascii_unit_tb.sv */
// Testbench for the signed integer to decimal text unit.
// Drives numbers, predicts their character streams and checks each character in order.
// Depends on itoa_pkg and signed_integer_to_decimal_ascii_unit.
`timescale 1ns / 1ps

module signed_integer_to_decimal_ascii_unit_tb import itoa_pkg::*; ();

	localparam int VALUE_BITS    = VALUE_BITS_DEF;
	localparam int DIRECTED_ROWS = 22;
	localparam int RANDOM_ITEMS  = 108;
	localparam int DRAIN_CYCLES  = 40;

	typedef struct packed {
		logic [CHAR_W-1:0] code;
		logic              is_last;
	} text_char_t;

	// a directed request; an empty text means the predictor supplies the characters
	typedef struct {
		logic [VALUE_BITS-1:0] num;
		string                 text;
	} number_row_t;

	typedef enum logic [1:0] {
		SINK_OPEN,
		SINK_THREE_OF_FOUR,
		SINK_COIN,
		SINK_TRICKLE
	} sink_mode_t;

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic [VALUE_BITS-1:0] value       = '0;
	logic                  value_valid = 1'b0;
	logic                  value_ready;
	logic [CHAR_W-1:0]     character;
	logic                  last;
	logic                  char_valid;
	logic                  char_ready  = 1'b0;

	text_char_t pending_text[$];
	int         fail_count = 0;
	sink_mode_t sink_mode  = SINK_OPEN;
	logic [7:0] sink_tick  = '0;

	number_row_t directed_rows[DIRECTED_ROWS] = '{
		'{32'd0,          "0"},
		'{32'd1,          "1"},
		'{32'hFFFF_FFFF,  "-1"},
		'{32'd9,          "9"},
		'{32'd10,         "10"},
		'{32'hFFFF_FFF6,  "-10"},
		'{32'd99,         ""},
		'{32'd100,        ""},
		'{32'h7FFF_FFFF,  "2147483647"},
		'{32'h8000_0000,  "-2147483648"},
		'{32'h8000_0001,  "-2147483647"},
		'{32'd1000000000, "1000000000"},
		'{32'hC465_3600,  "-1000000000"},
		'{32'd999999999,  ""},
		'{32'd1234567890, ""},
		'{32'hC521_97B1,  ""},
		'{32'h5555_5555,  ""},
		'{32'hAAAA_AAAA,  ""},
		'{32'd12345,      ""},
		'{32'hFFFF_2B4F,  ""},
		'{32'd7,          "7"},
		'{32'hFFFF_FFF8,  "-8"}
	};

	signed_integer_to_decimal_ascii_unit #(
		.VALUE_BITS(VALUE_BITS)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.value      (value),
		.value_valid(value_valid),
		.value_ready(value_ready),
		.character  (character),
		.last       (last),
		.char_valid (char_valid),
		.char_ready (char_ready)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// queue the expected text of one number: sign, then digits most significant first
	function automatic void push_decimal_text(input logic [VALUE_BITS-1:0] num);
		logic [VALUE_BITS-1:0] mag;
		logic [3:0]            digits[24];
		int                    count;
		count = 0;
		mag   = num[VALUE_BITS-1] ? -num : num;
		do begin
			digits[count] = 4'(mag % 10);
			mag           = mag / 10;
			count++;
		end while (mag != 0 && count < 24);
		if (num[VALUE_BITS-1])
			pending_text.push_back('{code: CHAR_MINUS, is_last: 1'b0});
		for (int d = count - 1; d >= 0; d--)
			pending_text.push_back('{code: CHAR_ZERO + CHAR_W'(digits[d]), is_last: d == 0});
	endfunction

	// queue a text typed in by hand
	function automatic void push_typed_text(input string text);
		byte b;
		for (int k = 0; k < text.len(); k++) begin
			b = text[k];
			pending_text.push_back('{code: b[CHAR_W-1:0], is_last: k == text.len() - 1});
		end
	endfunction

	// pick a random number: raw bits, a chosen digit count, small values or near the extremes
	function automatic logic [VALUE_BITS-1:0] random_number();
		logic [VALUE_BITS-1:0] num;
		logic [VALUE_BITS-1:0] lo;
		logic [VALUE_BITS-1:0] hi;
		int                    ndigits;
		case ($urandom_range(0, 3))
			0: num = $urandom();
			1: begin
				ndigits = $urandom_range(1, 10);
				lo = 1;
				for (int k = 1; k < ndigits; k++)
					lo = lo * 10;
				hi = (ndigits == 10) ? 32'h7FFF_FFFF : lo * 10 - 1;
				if (ndigits == 1)
					lo = 0;
				case ($urandom_range(0, 3))
					0:       num = lo;
					1:       num = hi;
					default: num = $urandom_range(hi, lo);
				endcase
				if ($urandom_range(0, 1))
					num = -num;
			end
			2: begin
				num = $urandom_range(0, 20);
				if ($urandom_range(0, 1))
					num = -num;
			end
			default: begin
				if ($urandom_range(0, 1))
					num = 32'h8000_0000 + $urandom_range(0, 3);
				else
					num = 32'h7FFF_FFFF - $urandom_range(0, 3);
			end
		endcase
		return num;
	endfunction

	// stall the character side: switch pattern whenever the low six tick bits wrap
	always @(posedge clk) begin
		sink_tick <= sink_tick + 1'b1;
		if (sink_tick[5:0] == 6'd63)
			sink_mode <= sink_mode_t'($urandom_range(0, 3));
		case (sink_mode)
			SINK_OPEN:          char_ready <= 1'b1;
			SINK_THREE_OF_FOUR: char_ready <= sink_tick[1:0] != 2'd3;
			SINK_COIN:          char_ready <= 1'($urandom_range(0, 1));
			default:            char_ready <= sink_tick[3:0] == 4'd0;
		endcase
	end

	// check every accepted character against the oldest expectation
	always @(posedge clk) begin
		text_char_t want;
		if (arst_n && char_valid && char_ready) begin
			if (pending_text.size() == 0) begin
				$display("%0t: unexpected character: expected none, actual code %0d last %0b",
					$time, character, last);
				fail_count++;
			end else begin
				want = pending_text.pop_front();
				if (character !== want.code) begin
					$display("%0t: character mismatch: expected %0d, actual %0d",
						$time, want.code, character);
					fail_count++;
				end
				if (last !== want.is_last) begin
					$display("%0t: last mismatch: expected %0b, actual %0b",
						$time, want.is_last, last);
					fail_count++;
				end
			end
		end
	end

	// reset, send directed then random requests in bursts, drain and report
	initial begin
		logic [VALUE_BITS-1:0] num;
		string                 text;
		int                    burst_left;
		int                    gap;
		burst_left = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);
		for (int i = 0; i < DIRECTED_ROWS + RANDOM_ITEMS; i++) begin
			if (i < DIRECTED_ROWS) begin
				num  = directed_rows[i].num;
				text = directed_rows[i].text;
			end else begin
				num  = random_number();
				text = "";
			end
			// open a new burst, idling first for a random gap
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 12);
				gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				if (gap > 0) begin
					value_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			burst_left--;
			value       <= num;
			value_valid <= 1'b1;
			do @(posedge clk); while (!value_ready);
			if (text.len() != 0)
				push_typed_text(text);
			else
				push_decimal_text(num);
		end
		value_valid <= 1'b0;
		while (pending_text.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("** signed_integer_to_decimal_ascii_unit: PASSED **");
		else
			$display("** signed_integer_to_decimal_ascii_unit: FAILED **");
		$finish;
	end

	// abort a hung run
	initial begin
		#5_000_000;
		$display("%0t: timeout with %0d characters outstanding", $time, pending_text.size());
		$display("** signed_integer_to_decimal_ascii_unit: FAILED **");
		$finish;
	end

endmodule
